/* sv/fcc_pkg.sv */
package fcc_pkg;

    // Coordinate width; points wrap modulo 2^COORD_BITS
    localparam int COORD_BITS = 16;

    // APB register map: register index sits at byte address 4*index
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [2:0]            t_code;
    typedef logic [1:0]            t_sidx;     // 0: -1, 1: 0, 2: +1

    typedef enum logic {
        REG_DECODE_MODE = 1'b0,
        REG_FOUR_CONN   = 1'b1
    } t_reg_idx;

    // Step in one axis: ok is low when the step is longer than one pixel
    typedef struct packed {
        logic  ok;
        t_sidx idx;
    } t_step;

    localparam logic [3:0] CODE_NONE = 4'd9;

    localparam t_sidx SIDX_NEG  = 2'd0;
    localparam t_sidx SIDX_ZERO = 2'd1;
    localparam t_sidx SIDX_POS  = 2'd2;

    // Direction code for (dx, dy), indexed [dx][dy]
    localparam logic [3:0] STEP_TO_CODE [3][3] = '{
        '{4'd7, 4'd0, 4'd1},
        '{4'd6, 4'd9, 4'd2},
        '{4'd5, 4'd4, 4'd3}
    };

    // Inverse mapping: x and y step for each code
    localparam t_sidx CODE_DX [8] = '{
        SIDX_NEG, SIDX_NEG, SIDX_ZERO, SIDX_POS,
        SIDX_POS, SIDX_POS, SIDX_ZERO, SIDX_NEG
    };
    localparam t_sidx CODE_DY [8] = '{
        SIDX_ZERO, SIDX_POS, SIDX_POS, SIDX_POS,
        SIDX_ZERO, SIDX_NEG, SIDX_NEG, SIDX_NEG
    };

    // Classify the modular difference cur - prev as -1, 0, +1 or too long
    function automatic t_step small_step(t_coord cur, t_coord prev);
        t_coord d;
        t_step  s;
        d = cur - prev;
        s.ok  = 1'b1;
        s.idx = SIDX_ZERO;
        if (d == t_coord'(1)) begin
            s.idx = SIDX_POS;
        end else if (d == '1) begin
            s.idx = SIDX_NEG;
        end else if (d != '0) begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

    // Move one coordinate by -1, 0 or +1 with wrap
    function automatic t_coord apply_step(t_coord p, t_sidx s);
        t_coord r;
        r = p;
        if (s == SIDX_POS) begin
            r = p + t_coord'(1);
        end else if (s == SIDX_NEG) begin
            r = p - t_coord'(1);
        end
        return r;
    endfunction

endpackage

/* sv/fcc_in_if.sv */
interface fcc_in_if
    import fcc_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   start_req;
    t_coord x_coord;
    t_coord y_coord;
    t_code  code_in;

    modport source (
        output valid, start_req, x_coord, y_coord, code_in,
        input  ready
    );
    modport sink (
        input  valid, start_req, x_coord, y_coord, code_in,
        output ready
    );
endinterface

/* sv/fcc_out_if.sv */
interface fcc_out_if
    import fcc_pkg::*;
;
    logic   valid;
    logic   ready;
    t_code  code_out;
    t_coord point_x;
    t_coord point_y;
    logic   last;
    logic   error;

    modport source (
        output valid, code_out, point_x, point_y, last, error,
        input  ready
    );
    modport sink (
        input  valid, code_out, point_x, point_y, last, error,
        output ready
    );
endinterface

/* sv/freeman_chain_code_codec.sv */
// Channel   Direction  Content
// i_in      sink       start_req, x_coord, y_coord, code_in
// o_res     source     code_out, point_x, point_y, last, error
// APB       slave      decode_mode (0x0), four_connected (0x4)
//
// Two register stages: an input register and a result register, with the
// step logic between them. One item per cycle while o_res is not stalled;
// a four-connected diagonal holds the input register for its second code.
// Reset is synchronous and clears the stage valid bits, the previous point
// and both configuration registers.
// A stall on o_res holds the input register; i_in keeps accepting until it fills.
module freeman_chain_code_codec
    import fcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcc_in_if.sink                i_in,
    fcc_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic     r_decode_mode;
    logic     r_four_conn;
    t_reg_idx reg_sel;
    logic     cfg_wr;

    logic     r_s1_valid;
    logic     r_s1_half;
    logic     r_s1_start;
    t_coord   r_s1_x;
    t_coord   r_s1_y;
    t_code    r_s1_code;

    t_coord   r_prev_x;
    t_coord   r_prev_y;
    t_coord   n_prev_x;
    t_coord   n_prev_y;

    logic     r_out_valid;
    t_code    r_out_code;
    t_coord   r_out_x;
    t_coord   r_out_y;
    logic     r_out_last;
    logic     r_out_err;

    t_step       sx;
    t_step       sy;
    logic [3:0]  enc_code;
    logic        enc_bad;
    logic        diag;
    logic        has_result;
    logic        out_free;
    logic        s1_fire;
    logic        s1_split;
    logic        s1_done;
    logic        emit;
    t_coord      dec_x;
    t_coord      dec_y;
    t_code       res_code;
    t_coord      res_x;
    t_coord      res_y;
    logic        res_last;
    logic        res_err;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_DECODE_MODE: prdata[0] = r_decode_mode;
            REG_FOUR_CONN:   prdata[0] = r_four_conn;
            default:         prdata    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_four_conn   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_DECODE_MODE: r_decode_mode <= pwdata[0];
                REG_FOUR_CONN:   r_four_conn   <= pwdata[0];
                default:         r_decode_mode <= r_decode_mode;
            endcase
        end
    end

    // Step logic on the input register
    assign sx       = small_step(r_s1_x, r_prev_x);
    assign sy       = small_step(r_s1_y, r_prev_y);
    assign enc_code = STEP_TO_CODE[sx.idx][sy.idx];
    assign enc_bad  = !(sx.ok && sy.ok) || (enc_code == CODE_NONE);
    assign diag     = r_four_conn && !enc_bad && enc_code[0];

    assign dec_x = r_s1_start ? r_s1_x : apply_step(r_prev_x, CODE_DX[r_s1_code]);
    assign dec_y = r_s1_start ? r_s1_y : apply_step(r_prev_y, CODE_DY[r_s1_code]);

    // Handshake: an encode start item leaves without a result
    assign has_result = r_decode_mode || !r_s1_start;
    assign out_free   = !r_out_valid || o_res.ready;
    assign s1_fire    = r_s1_valid && (out_free || !has_result);
    assign s1_split   = s1_fire && !r_decode_mode && !r_s1_start && diag && !r_s1_half;
    assign s1_done    = s1_fire && !s1_split;
    assign emit       = s1_fire && has_result;
    assign i_in.ready = !r_s1_valid || s1_done;

    // Result fields
    always_comb begin
        res_code = '0;
        res_x    = '0;
        res_y    = '0;
        res_last = 1'b1;
        res_err  = 1'b0;
        if (r_decode_mode) begin
            res_x = dec_x;
            res_y = dec_y;
        end else if (enc_bad) begin
            res_err = 1'b1;
        end else if (diag) begin
            // even code after the diagonal first, then the one before it
            res_code = r_s1_half ? (enc_code[2:0] + 3'd7) : (enc_code[2:0] + 3'd1);
            res_last = r_s1_half;
        end else begin
            res_code = enc_code[2:0];
        end
    end

    assign n_prev_x = r_decode_mode ? dec_x : r_s1_x;
    assign n_prev_y = r_decode_mode ? dec_y : r_s1_y;

    // Input register control and previous point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_half  <= 1'b0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_split) begin
                r_s1_half <= 1'b1;
            end else if (s1_done) begin
                r_s1_half <= 1'b0;
            end
            if (s1_done) begin
                r_prev_x <= n_prev_x;
                r_prev_y <= n_prev_y;
            end
        end
    end

    // Capture the transaction payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_start <= i_in.start_req;
            r_s1_x     <= i_in.x_coord;
            r_s1_y     <= i_in.y_coord;
            r_s1_code  <= i_in.code_in;
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_code <= res_code;
            r_out_x    <= res_x;
            r_out_y    <= res_y;
            r_out_last <= res_last;
            r_out_err  <= res_err;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.code_out = r_out_code;
    assign o_res.point_x  = r_out_x;
    assign o_res.point_y  = r_out_y;
    assign o_res.last     = r_out_last;
    assign o_res.error    = r_out_err;

endmodule
